// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, including those inside reset.
`define LIRS_ASSERT_ALWAYS(name, clk_s, prop) \
    name: assert property (@(posedge clk_s) prop) \
        else $error("%m: assertion failed");

// Checked only while reset is released.
`define LIRS_ASSERT_GUARDED(name, clk_s, rstn_s, prop) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
        else $error("%m: assertion failed");

`endif

// ===== src/lirs_pkg.sv =====
package lirs_pkg;

    localparam int SAMPLE_BITS_DEF  = 24;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int MAX_RUN_BITS_DEF = 20;

    localparam int STEP_BITS   = 21;
    localparam int MAX_RESULTS = 32;
    localparam int COUNT_BITS  = $clog2(MAX_RESULTS + 1);

    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BYPASS = 2'd1;

    localparam logic [STEP_BITS-1:0] STEP_RESET = 21'd65536;

    typedef struct packed {
        logic last;
        logic bypass;
    } lirs_flags_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL,
        ST_OUT,
        ST_FINISH
    } lirs_state_t;

endpackage

// ===== src/lirs_front.sv =====
module lirs_front #(
    parameter int SAMPLE_BITS = lirs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          last_in,
    input  logic                          bypass,
    output logic                          q_valid,
    output logic signed [SAMPLE_BITS-1:0] q_sample,
    output lirs_pkg::lirs_flags_t         q_flags,
    input  logic                          q_pop
);
    import lirs_pkg::*;

    // Two-entry queue; each word is tagged with its mode as it is accepted.
    logic signed [SAMPLE_BITS-1:0] sample_mem_reg [2];
    lirs_flags_t                   flags_mem_reg  [2];
    logic                          wr_ptr_reg;
    logic                          wr_ptr_next;
    logic                          rd_ptr_reg;
    logic                          rd_ptr_next;
    logic [1:0]                    count_reg;
    logic [1:0]                    count_next;
    logic                          push;
    logic                          pop;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && q_valid;
    assign q_valid  = (count_reg != 2'd0);
    assign q_sample = sample_mem_reg[rd_ptr_reg];
    assign q_flags  = flags_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            sample_mem_reg[wr_ptr_reg]      <= sample_in;
            flags_mem_reg[wr_ptr_reg].last   <= last_in;
            flags_mem_reg[wr_ptr_reg].bypass <= bypass;
        end
    end

endmodule

// ===== src/lirs_back.sv =====
module lirs_back #(
    parameter int SAMPLE_BITS  = lirs_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS    = lirs_pkg::FRAC_BITS_DEF,
    parameter int MAX_RUN_BITS = lirs_pkg::MAX_RUN_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_valid,
    input  logic signed [SAMPLE_BITS-1:0]    q_sample,
    input  lirs_pkg::lirs_flags_t            q_flags,
    output logic                             q_pop,
    input  logic [lirs_pkg::STEP_BITS-1:0]   step,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [SAMPLE_BITS-1:0]    sample_out,
    output logic                             last_out
);
    import lirs_pkg::*;

    localparam int POS_BITS  = MAX_RUN_BITS + FRAC_BITS;
    localparam int WIDE_BITS = (POS_BITS > STEP_BITS) ? POS_BITS : STEP_BITS;
    localparam int REL_BITS  = WIDE_BITS + COUNT_BITS + 1;
    localparam int PROD_BITS = SAMPLE_BITS + FRAC_BITS + 2;

    localparam logic [REL_BITS-1:0]  REL_ONE  = {{(REL_BITS-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [REL_BITS-1:0]  REL_TWO  = REL_ONE << 1;
    localparam logic [POS_BITS-1:0]  POS_TWO  = {{(POS_BITS-1){1'b0}}, 1'b1} << (FRAC_BITS + 1);
    localparam logic [STEP_BITS-1:0] MIN_STEP =
        {{(STEP_BITS-1){1'b0}}, 1'b1} << (FRAC_BITS - 4);
    localparam logic [COUNT_BITS-1:0] N_MAX  = COUNT_BITS'(MAX_RESULTS);

    lirs_state_t state_reg;
    lirs_state_t state_next;

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] x_next;
    logic                          last_reg;
    logic                          last_next;
    logic                          byp_reg;
    logic                          byp_next;
    logic signed [SAMPLE_BITS-1:0] prev_reg;
    logic signed [SAMPLE_BITS-1:0] prev_next;
    logic                          have_prev_reg;
    logic                          have_prev_next;
    logic [POS_BITS-1:0]           pos_reg;
    logic [POS_BITS-1:0]           pos_next;
    logic [MAX_RUN_BITS-1:0]       cnt_reg;
    logic [MAX_RUN_BITS-1:0]       cnt_next;
    logic [REL_BITS-1:0]           rel_reg;
    logic [REL_BITS-1:0]           rel_next;
    logic [COUNT_BITS-1:0]         n_reg;
    logic [COUNT_BITS-1:0]         n_next;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [PROD_BITS-1:0]   prod_next;
    logic signed [SAMPLE_BITS-1:0] val_reg;
    logic signed [SAMPLE_BITS-1:0] val_next;
    logic                          pend_valid_reg;
    logic                          pend_valid_next;
    logic signed [SAMPLE_BITS-1:0] pend_reg;
    logic signed [SAMPLE_BITS-1:0] pend_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_next;
    logic                          out_last_reg;
    logic                          out_last_next;

    logic [STEP_BITS-1:0]          st_eff;
    logic [MAX_RUN_BITS-1:0]       base;
    logic [POS_BITS-1:0]           rel_start;
    logic [POS_BITS-1:0]           relp;
    logic                          can_interp;
    logic                          can_copy;
    logic                          out_ready;
    logic                          end_run;
    logic                          need_push;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [FRAC_BITS:0]     frac_s;
    logic signed [PROD_BITS-1:0]   acc;
    logic signed [PROD_BITS-1:0]   quot;

    assign st_eff     = (step < MIN_STEP) ? MIN_STEP : step;
    assign base       = have_prev_reg ? (cnt_reg - 1'b1) : cnt_reg;
    assign rel_start  = pos_reg - {base, {FRAC_BITS{1'b0}}};
    assign relp       = pos_reg - {cnt_reg, {FRAC_BITS{1'b0}}};
    assign can_interp = have_prev_reg && (rel_reg < REL_ONE) && (n_reg < N_MAX);
    assign can_copy   = last_reg && (rel_reg < (have_prev_reg ? REL_TWO : REL_ONE))
                        && (n_reg < N_MAX);
    assign out_ready  = !out_valid_reg || !out_stall;
    assign end_run    = byp_reg || last_reg;
    assign need_push  = pend_valid_reg && (end_run || (relp < POS_TWO));

    assign diff   = (SAMPLE_BITS+1)'(x_reg) - (SAMPLE_BITS+1)'(prev_reg);
    assign frac_s = $signed({1'b0, rel_reg[FRAC_BITS-1:0]});

    always_comb
    begin
        acc  = (PROD_BITS'(prev_reg) <<< FRAC_BITS) + prod_reg;
        quot = acc >>> FRAC_BITS;
        if (acc[PROD_BITS-1] && (|acc[FRAC_BITS-1:0]))
        begin
            quot = quot + PROD_BITS'(1);
        end
    end

    assign q_pop      = (state_reg == ST_IDLE) && q_valid;
    assign out_valid  = out_valid_reg;
    assign sample_out = out_sample_reg;
    assign last_out   = out_last_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (byp_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (can_interp)
                begin
                    state_next = ST_MUL;
                end
                else if (can_copy)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_MUL:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!pend_valid_reg || out_ready)
                begin
                    state_next = byp_reg ? ST_FINISH : ST_DECIDE;
                end
            end
            ST_FINISH:
            begin
                if (!need_push || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        x_next          = x_reg;
        last_next       = last_reg;
        byp_next        = byp_reg;
        prev_next       = prev_reg;
        have_prev_next  = have_prev_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        rel_next        = rel_reg;
        n_next          = n_reg;
        prod_next       = prod_reg;
        val_next        = val_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    x_next    = q_sample;
                    last_next = q_flags.last;
                    byp_next  = q_flags.bypass;
                    rel_next  = REL_BITS'(rel_start);
                    n_next    = pend_valid_reg ? COUNT_BITS'(1) : COUNT_BITS'(0);
                end
            end
            ST_DECIDE:
            begin
                val_next  = x_reg;
                prod_next = PROD_BITS'(diff * frac_s);
            end
            ST_MUL:
            begin
                val_next = quot[SAMPLE_BITS-1:0];
            end
            ST_OUT:
            begin
                if (!pend_valid_reg || out_ready)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_sample_next = pend_reg;
                        out_last_next   = 1'b0;
                    end
                    pend_next       = val_reg;
                    pend_valid_next = 1'b1;
                    n_next          = n_reg + COUNT_BITS'(1);
                    if (!byp_reg)
                    begin
                        rel_next = rel_reg + REL_BITS'(st_eff);
                        pos_next = pos_reg + POS_BITS'(st_eff);
                    end
                end
            end
            ST_FINISH:
            begin
                if (!need_push || out_ready)
                begin
                    if (need_push)
                    begin
                        out_valid_next  = 1'b1;
                        out_sample_next = pend_reg;
                        out_last_next   = last_reg;
                        pend_valid_next = 1'b0;
                    end
                    if (end_run)
                    begin
                        prev_next      = '0;
                        have_prev_next = 1'b0;
                        pos_next       = '0;
                        cnt_next       = '0;
                    end
                    else
                    begin
                        prev_next      = x_reg;
                        have_prev_next = 1'b1;
                        cnt_next       = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            prev_reg       <= '0;
            have_prev_reg  <= 1'b0;
            pos_reg        <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            prev_reg       <= prev_next;
            have_prev_reg  <= have_prev_next;
            pos_reg        <= pos_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        last_reg       <= last_next;
        byp_reg        <= byp_next;
        rel_reg        <= rel_next;
        n_reg          <= n_next;
        prod_reg       <= prod_next;
        val_reg        <= val_next;
        pend_reg       <= pend_next;
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
    end

endmodule

// ===== src/linear_interp_resampler_core.sv =====
// Linear-interpolation sample-rate converter for one mono audio stream.
// Input channel: one signed source sample per word, with last_in marking the
// final sample of a run. Output channel: resampled words, with last_out on the
// final output of the run. Both channels move a word when valid is high and
// stall is low. The configuration channel writes step (index 0, source samples
// per output, unsigned 5.16) and bypass (index 1) whenever valid and ready
// are high; ready is always high. Writes are to be made only while the block
// is idle; the block itself does not enforce this. A two-word queue takes
// input words while the back-end sequencer works. Per source word the
// sequencer passes through ST_IDLE, ST_DECIDE and ST_FINISH; an interpolated
// output takes ST_DECIDE (one shared multiplier), ST_MUL (the rounding step)
// and ST_OUT, a copied output ST_DECIDE and ST_OUT, and a bypassed word
// ST_IDLE, ST_DECIDE, ST_OUT and ST_FINISH. The newest output waits in a
// holding register until the next output is formed or the word finishes.
// That newest output may be held back until the next word when a large step
// means the run could end without producing another output. A stalled
// receiver holds the output register; the sequencer then waits and the queue
// fills, after which in_stall rises. Reset sets step to 1.0, clears bypass,
// empties queue and output register and starts a fresh run.
module linear_interp_resampler_core #(
    parameter int SAMPLE_BITS  = lirs_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS    = lirs_pkg::FRAC_BITS_DEF,
    parameter int MAX_RUN_BITS = lirs_pkg::MAX_RUN_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       sample_in,
    input  logic                                last_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [SAMPLE_BITS-1:0]       sample_out,
    output logic                                last_out,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lirs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lirs_pkg::STEP_BITS-1:0]      cfg_data
);
    import lirs_pkg::*;

    logic [STEP_BITS-1:0]          step_reg;
    logic                          bypass_reg;
    logic                          q_valid;
    logic signed [SAMPLE_BITS-1:0] q_sample;
    lirs_flags_t                   q_flags;
    logic                          q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= STEP_RESET;
            bypass_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_STEP:   step_reg   <= cfg_data;
                CFG_BYPASS: bypass_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    lirs_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample_in (sample_in),
        .last_in   (last_in),
        .bypass    (bypass_reg),
        .q_valid   (q_valid),
        .q_sample  (q_sample),
        .q_flags   (q_flags),
        .q_pop     (q_pop)
    );

    lirs_back #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .FRAC_BITS    (FRAC_BITS),
        .MAX_RUN_BITS (MAX_RUN_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_sample   (q_sample),
        .q_flags    (q_flags),
        .q_pop      (q_pop),
        .step       (step_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .last_out   (last_out)
    );

endmodule

// ===== src/lirs_checker.sv =====
`include "assert_macros.svh"

module lirs_checker #(
    parameter int SAMPLE_BITS = lirs_pkg::SAMPLE_BITS_DEF
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [SAMPLE_BITS-1:0]       sample_out,
    input logic                                last_out
);
    import lirs_pkg::*;

    // While reset is held, no word is offered and the queue is open.
    `LIRS_ASSERT_ALWAYS(a_reset_out_idle, clk, !rst_n |=> !out_valid)
    `LIRS_ASSERT_ALWAYS(a_reset_in_open, clk, !rst_n |=> !in_stall)

    // The queue can only fill up on an accepted input word.
    `LIRS_ASSERT_GUARDED(a_stall_after_accept, clk, rst_n, $rose(in_stall) |-> $past(in_valid && !in_stall))

    `LIRS_ASSERT_GUARDED(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(last_out))

endmodule

bind linear_interp_resampler_core lirs_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_lirs_checker (.*);

// ===== tb/linear_interp_resampler_core_tb.sv =====
module linear_interp_resampler_core_tb;

    import lirs_pkg::*;

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int RB = MAX_RUN_BITS_DEF;
    localparam int PB = RB + FB;
    localparam logic [63:0] ONE = 64'd1 << FB;
    localparam logic [63:0] MIN_STEP = 64'd1 << (FB - 4);
    localparam int STEP_MAX = (1 << STEP_BITS) - 1;
    localparam int SETTLE_CYCLES = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int RUN_LIMIT = 4000000;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_2 = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_3 = 2'd3;

    typedef logic signed [SB-1:0] sample_t;
    typedef struct packed {
        sample_t value;
        logic    last;
    } word_t;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    sample_t                   sample_in = '0;
    logic                      last_in = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    sample_t                   sample_out;
    logic                      last_out;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [STEP_BITS-1:0]      cfg_data = '0;

    word_t pending_samples[$];
    word_t expected_outputs[$];
    logic  in_taken = 1'b0;
    int    errors = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    bit    hold_request = 0;
    int    hold_left = 0;

    logic [STEP_BITS-1:0] step_reg;
    logic                 bypass_reg;
    sample_t              prev_sample;
    bit                   have_prev;
    logic [PB-1:0]        out_pos;
    logic [RB-1:0]        in_count;
    bit                   held_valid;
    sample_t              held_sample;

    int idle_send[4] = '{0, 79, 0, 31};
    int idle_recv[4] = '{0, 0, 79, 31};

    linear_interp_resampler_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .last_in    (last_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .last_out   (last_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void clear_run();
        prev_sample = '0;
        have_prev   = 0;
        out_pos     = '0;
        in_count    = '0;
        held_valid  = 0;
        held_sample = '0;
    endfunction

    function automatic sample_t blend(input sample_t a, input sample_t b, input logic [63:0] f);
        longint acc;
        longint q;
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (SB - 1)) - 1;
        lo = -hi - 1;
        acc = longint'(a) * longint'(ONE - f) + longint'(b) * longint'(f);
        q = acc / longint'(ONE);
        if (q > hi)
        begin
            q = hi;
        end
        if (q < lo)
        begin
            q = lo;
        end
        return q[SB-1:0];
    endfunction

    task automatic predict_outputs(input word_t w);
        sample_t       outs[$];
        word_t         o;
        logic [63:0]   st;
        logic [63:0]   rel;
        logic [63:0]   relp;
        logic [63:0]   lim;
        logic [RB-1:0] base_cnt;
        logic [PB-1:0] pos_diff;
        st = step_reg;
        if (st < MIN_STEP)
        begin
            st = MIN_STEP;
        end
        if (held_valid)
        begin
            outs.push_back(held_sample);
        end
        held_valid = 0;
        if (bypass_reg)
        begin
            outs.push_back(w.value);
            clear_run();
        end
        else
        begin
            base_cnt = have_prev ? in_count - 1'b1 : in_count;
            pos_diff = out_pos - {base_cnt, {FB{1'b0}}};
            rel = pos_diff;
            if (have_prev)
            begin
                while (rel < ONE && outs.size() < MAX_RESULTS)
                begin
                    outs.push_back(blend(prev_sample, w.value, rel));
                    rel = rel + st;
                    out_pos = out_pos + st[PB-1:0];
                end
            end
            if (w.last)
            begin
                lim = have_prev ? 2 * ONE : ONE;
                while (rel < lim && outs.size() < MAX_RESULTS)
                begin
                    outs.push_back(w.value);
                    rel = rel + st;
                    out_pos = out_pos + st[PB-1:0];
                end
                clear_run();
            end
            else
            begin
                pos_diff = out_pos - {in_count, {FB{1'b0}}};
                relp = pos_diff;
                prev_sample = w.value;
                have_prev = 1;
                in_count = in_count + 1'b1;
                if (outs.size() > 0 && relp >= 2 * ONE)
                begin
                    held_sample = outs.pop_back();
                    held_valid = 1;
                end
            end
        end
        foreach (outs[k])
        begin
            o.value = outs[k];
            o.last  = w.last && (k == outs.size() - 1);
            expected_outputs.push_back(o);
        end
    endtask

    always @(posedge clk)
    begin : take_sample
        word_t w;
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            w.value = sample_in;
            w.last  = last_in;
            predict_outputs(w);
        end
    end

    always @(negedge clk)
    begin : feed_samples
        word_t w;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                w = pending_samples.pop_front();
                in_valid  <= 1'b1;
                sample_in <= w.value;
                last_in   <= w.last;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : pace_receiver
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_request)
        begin
            hold_request = 0;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_output
        word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_outputs.size() == 0)
            begin
                errors = errors + 1;
                $display("%0t: unexpected word: expected none, actual sample %0d last %0b",
                         $time, sample_out, last_out);
            end
            else
            begin
                want = expected_outputs.pop_front();
                if (sample_out !== want.value)
                begin
                    errors = errors + 1;
                    $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                             $time, want.value, sample_out);
                end
                if (last_out !== want.last)
                begin
                    errors = errors + 1;
                    $display("%0t: last_out mismatch: expected %0b, actual %0b",
                             $time, want.last, last_out);
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [STEP_BITS-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (cfg_ready !== 1'b1);
        case (index)
            CFG_STEP:   step_reg = value;
            CFG_BYPASS: bypass_reg = value[0];
            default:    ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_bypass(input bit on);
        logic [STEP_BITS-1:0] value;
        value = STEP_BITS'($urandom);
        value[0] = on;
        write_reg(CFG_BYPASS, value);
    endtask

    task automatic queue_word(input sample_t value, input logic last);
        word_t w;
        w.value = value;
        w.last  = last;
        pending_samples.push_back(w);
    endtask

    task automatic set_idling(input int mode);
        send_idle_pct  = idle_send[mode];
        recv_stall_pct = idle_recv[mode];
    endtask

    task automatic drain_block();
        while (pending_samples.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        while (expected_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic sample_t rand_sample();
        sample_t v;
        case ($urandom_range(7))
            0:       v = {1'b0, {(SB - 1){1'b1}}};
            1:       v = {1'b1, {(SB - 1){1'b0}}};
            2:       v = SB'($urandom_range(16) - 8);
            default: v = SB'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [STEP_BITS-1:0] rand_step();
        logic [STEP_BITS-1:0] v;
        case ($urandom_range(5))
            0:
            begin
                case ($urandom_range(5))
                    0:       v = 21'd0;
                    1:       v = 21'd4095;
                    2:       v = 21'd4096;
                    3:       v = 21'd65536;
                    4:       v = 21'd1048576;
                    default: v = STEP_BITS'(STEP_MAX);
                endcase
            end
            1, 2:    v = STEP_BITS'($urandom_range(4096, 1048576));
            3, 4:    v = STEP_BITS'($urandom_range(40000, 100000));
            default: v = STEP_BITS'($urandom_range(STEP_MAX));
        endcase
        return v;
    endfunction

    task automatic queue_random_words(input int count);
        int done;
        int len;
        done = 0;
        while (done < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                queue_word(rand_sample(), 1'($urandom_range(1)));
                done = done + 1;
            end
            else
            begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                begin
                    queue_word(rand_sample(), i == len - 1);
                end
                done = done + len;
            end
        end
        queue_word(rand_sample(), 1'b1);
    endtask

    initial
    begin
        step_reg = STEP_RESET;
        bypass_reg = 1'b0;
        clear_run();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_idling(0);
        write_reg(CFG_STEP, 21'd65536);
        write_bypass(1'b0);
        write_reg(CFG_UNUSED_2, STEP_BITS'($urandom));
        write_reg(CFG_UNUSED_3, STEP_BITS'($urandom));
        queue_word({1'b0, {(SB - 1){1'b1}}}, 1'b0);
        queue_word({1'b1, {(SB - 1){1'b0}}}, 1'b0);
        queue_word('0, 1'b0);
        queue_word('1, 1'b0);
        queue_word(SB'(1), 1'b0);
        queue_word({1'b0, {(SB - 1){1'b1}}}, 1'b1);
        drain_block();

        set_idling(3);
        write_reg(CFG_STEP, 21'd32768);
        queue_word('1, 1'b0);
        queue_word('0, 1'b0);
        queue_word({1'b0, {(SB - 1){1'b1}}}, 1'b0);
        queue_word({1'b1, {(SB - 1){1'b0}}}, 1'b1);
        drain_block();

        write_reg(CFG_STEP, 21'd0);
        queue_word(SB'(100), 1'b0);
        queue_word({1'b1, {(SB - 1){1'b0}}}, 1'b1);
        queue_word(SB'(5), 1'b1);
        drain_block();

        // A very large step leaves an output held back when the run stops mid-way.
        write_reg(CFG_STEP, 21'(STEP_MAX));
        queue_word(SB'(1000), 1'b0);
        queue_word(SB'(-2000), 1'b0);
        queue_word(SB'(3000), 1'b0);
        queue_word(SB'(-4000), 1'b0);
        drain_block();
        write_bypass(1'b1);
        queue_word(SB'(77), 1'b0);
        queue_word(SB'(-77), 1'b1);
        drain_block();

        write_bypass(1'b0);
        write_reg(CFG_STEP, 21'd1048576);
        queue_word(SB'(11), 1'b0);
        queue_word(SB'(-22), 1'b0);
        queue_word(SB'(33), 1'b0);
        queue_word(SB'(-44), 1'b1);
        drain_block();

        for (int phase = 0; phase < 8; phase++)
        begin
            set_idling(phase % 4);
            write_reg(CFG_STEP, rand_step());
            write_bypass($urandom_range(4) == 0);
            queue_random_words(33);
            drain_block();
        end

        // The receiver holds off for a long stretch so that the input side backs up.
        set_idling(0);
        write_reg(CFG_STEP, 21'd4096);
        write_bypass(1'b0);
        hold_request = 1;
        queue_random_words(30);
        drain_block();

        if (errors == 0)
        begin
            $display("linear_interp_resampler_core_tb passed");
        end
        else
        begin
            $display("linear_interp_resampler_core_tb failed");
        end
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("linear_interp_resampler_core_tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/lirs_pkg.sv
src/lirs_front.sv
src/lirs_back.sv
src/linear_interp_resampler_core.sv
src/lirs_checker.sv
tb/linear_interp_resampler_core_tb.sv
